// ===== rtl/core/healpix_index_converter_core_defines.svh =====
// assertion macros shared by the converter modules
`ifndef HEALPIX_INDEX_CONVERTER_CORE_DEFINES_SVH
`define HEALPIX_INDEX_CONVERTER_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define HIC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define HIC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/hic_pkg.sv =====
package hic_pkg;

  localparam int MAX_ORDER   = 13;
  localparam int ORD_W       = 4;
  localparam int PIX_W       = 30;
  localparam int QUEUE_DEPTH = 4;
  // one result bit per step, enough for the largest cap argument
  localparam int SQRT_STEPS  = MAX_ORDER + 1;
  localparam int SQ_W        = 2 * SQRT_STEPS;

  localparam logic FUNC_N2R = 1'b0;
  localparam logic FUNC_R2N = 1'b1;

  typedef enum logic [2:0] {
    REG_NORTH = 3'b001,
    REG_BELT  = 3'b010,
    REG_SOUTH = 3'b100
  } hic_region_t;

  typedef struct packed {
    logic             func;
    logic [PIX_W-1:0] pixel_index;
  } hic_in_t;

  typedef struct packed {
    logic [PIX_W-1:0] converted_index;
    logic             index_error;
  } hic_out_t;

  // classified item between front and back
  typedef struct packed {
    logic             func;
    logic             err;
    logic [ORD_W-1:0] ord;
    hic_region_t      region;
    logic [PIX_W-1:0] pix;
  } hic_work_t;

  function automatic logic [2:0] ring_row(input logic [3:0] face);
    logic [2:0] r;
    r = 3'd0;
    unique case (face)
      4'd0, 4'd1, 4'd2, 4'd3:   r = 3'd2;
      4'd4, 4'd5, 4'd6, 4'd7:   r = 3'd3;
      4'd8, 4'd9, 4'd10, 4'd11: r = 3'd4;
      default:                  r = 3'd0;
    endcase
    return r;
  endfunction

  function automatic logic [2:0] ring_col(input logic [3:0] face);
    logic [2:0] c;
    c = 3'd0;
    unique case (face)
      4'd0, 4'd8:  c = 3'd1;
      4'd1, 4'd9:  c = 3'd3;
      4'd2, 4'd10: c = 3'd5;
      4'd3, 4'd11: c = 3'd7;
      4'd4:        c = 3'd0;
      4'd5:        c = 3'd2;
      4'd6:        c = 3'd4;
      4'd7:        c = 3'd6;
      default:     c = 3'd0;
    endcase
    return c;
  endfunction

  function automatic logic [31:0] spread16(input logic [15:0] v);
    logic [31:0] r;
    r = '0;
    for (int i = 0; i < 16; i++) begin
      r[2*i] = v[i];
    end
    return r;
  endfunction

  function automatic logic [15:0] gather16(input logic [31:0] v);
    logic [15:0] r;
    r = '0;
    for (int i = 0; i < 16; i++) begin
      r[i] = v[2*i];
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/hic_front.sv =====
module hic_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [hic_pkg::ORD_W-1:0]  cfg_data,
  input  logic                       src_valid,
  output logic                       src_ready,
  input  hic_pkg::hic_in_t           src_item,
  output logic                       wq_valid,
  input  logic                       wq_ready,
  output hic_pkg::hic_work_t         wq_item
);

  logic [hic_pkg::ORD_W-1:0] ord_reg;
  logic [hic_pkg::ORD_W-1:0] ord_eff;
  logic                      fv;
  hic_pkg::hic_work_t        fitem;
  hic_pkg::hic_work_t        fitem_next;
  logic [31:0]               npix;
  logic [31:0]               ncap;
  logic [31:0]               pixv;

  assign cfg_ready = 1'b1;
  assign src_ready = !fv || wq_ready;
  assign wq_valid  = fv;
  assign wq_item   = fitem;

  always_ff @(posedge clk) begin
    if (rst) begin
      ord_reg <= '0;
    end else if (cfg_valid) begin
      ord_reg <= cfg_data;
    end
  end

  // saturate orders above the supported maximum
  assign ord_eff = (ord_reg > hic_pkg::ORD_W'(hic_pkg::MAX_ORDER)) ?
                   hic_pkg::ORD_W'(hic_pkg::MAX_ORDER) : ord_reg;

  always_comb begin
    pixv = 32'(src_item.pixel_index);
    npix = 32'd12 << {ord_eff, 1'b0};
    ncap = (32'd2 << {ord_eff, 1'b0}) - (32'd2 << ord_eff);
    fitem_next.func = src_item.func;
    fitem_next.err  = (pixv >= npix);
    fitem_next.ord  = ord_eff;
    fitem_next.pix  = src_item.pixel_index;
    priority if (pixv < ncap) begin
      fitem_next.region = hic_pkg::REG_NORTH;
    end else if (pixv < npix - ncap) begin
      fitem_next.region = hic_pkg::REG_BELT;
    end else begin
      fitem_next.region = hic_pkg::REG_SOUTH;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= 1'b0;
    end else if (src_ready) begin
      fv <= src_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (src_ready && src_valid) begin
      fitem <= fitem_next;
    end
  end

endmodule

// ===== rtl/core/hic_queue.sv =====
`include "healpix_index_converter_core_defines.svh"

module hic_queue #(
  parameter int DEPTH = hic_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push_valid,
  output logic               push_ready,
  input  hic_pkg::hic_work_t push_item,
  output logic               pop_valid,
  input  logic               pop_ready,
  output hic_pkg::hic_work_t pop_item
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  hic_pkg::hic_work_t mem [DEPTH];
  logic [AW-1:0]      wr_ptr;
  logic [AW-1:0]      rd_ptr;
  logic [CW-1:0]      count;
  logic               push;
  logic               pop;

  assign push_ready = (count != CW'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_item   = mem[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `HIC_ASSERT_NOW(a_count_bound, clk, rst, 1'b1, count <= CW'(DEPTH), "queue count over depth")
  `HIC_ASSERT_NEXT(a_pop_only, clk, rst, pop && !push, count == $past(count) - 1'b1, "queue count slip")

endmodule

// ===== rtl/core/hic_back.sv =====
`include "healpix_index_converter_core_defines.svh"

module hic_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  hic_pkg::hic_work_t in_item,
  output logic               res_valid,
  input  logic               res_ready,
  output hic_pkg::hic_out_t  res_item
);

  localparam int STEPS = hic_pkg::SQRT_STEPS;
  localparam int SW    = hic_pkg::SQ_W;

  typedef struct packed {
    logic                      func;
    logic                      err;
    logic [hic_pkg::ORD_W-1:0] ord;
    hic_pkg::hic_region_t      region;
    logic [hic_pkg::PIX_W-1:0] pix;
    logic [3:0]                face;
    logic [13:0]               ix;
    logic [13:0]               iy;
    logic signed [31:0]        jr;
    logic signed [31:0]        ip;
    logic signed [31:0]        iphi;
    logic signed [31:0]        iring;
    logic signed [31:0]        prod;
    logic signed [31:0]        ring_start;
    logic signed [31:0]        jpn;
    logic signed [31:0]        jp;
    logic signed [31:0]        irt;
    logic signed [31:0]        ipt;
    logic signed [31:0]        res;
    logic [15:0]               tmp;
    logic signed [15:0]        nr;
    logic                      kshift;
    logic [SW-1:0]             sq_v;
    logic [SW-1:0]             sq_r;
  } ctx_t;

  logic en;
  assign en       = !res_valid || res_ready;
  assign in_ready = en;

  // ---------------- prep stage
  logic  v1;
  ctx_t  c1, c1_next;

  always_comb begin
    logic signed [31:0] nside, npix, ncap, pixs, rowv, arg;
    logic [31:0]        lcl;
    logic [15:0]        gx, gy;
    nside = 32'sd1 <<< in_item.ord;
    npix  = 32'sd12 <<< {in_item.ord, 1'b0};
    ncap  = (32'sd2 <<< {in_item.ord, 1'b0}) - (32'sd2 <<< in_item.ord);
    pixs  = 32'(in_item.pix);
    c1_next        = '0;
    c1_next.func   = in_item.func;
    c1_next.err    = in_item.err;
    c1_next.ord    = in_item.ord;
    c1_next.region = in_item.region;
    c1_next.pix    = in_item.pix;
    c1_next.face   = 4'(in_item.pix >> {in_item.ord, 1'b0});
    lcl = 32'(in_item.pix) & ((32'd1 << {in_item.ord, 1'b0}) - 32'd1);
    gx  = hic_pkg::gather16(lcl);
    gy  = hic_pkg::gather16(lcl >> 1);
    c1_next.ix = gx[13:0];
    c1_next.iy = gy[13:0];
    rowv = 32'(hic_pkg::ring_row(c1_next.face));
    c1_next.jr = (rowv <<< in_item.ord) - 32'(c1_next.ix) - 32'(c1_next.iy) - 32'sd1;
    arg = '0;
    unique case (in_item.region)
      hic_pkg::REG_NORTH: begin
        arg = 32'sd2 * pixs + 32'sd1;
      end
      hic_pkg::REG_BELT: begin
        c1_next.ip   = pixs - ncap;
        c1_next.tmp  = 16'(c1_next.ip >>> (in_item.ord + 3'd2));
        c1_next.iphi = (c1_next.ip & ((nside <<< 2) - 32'sd1)) + 32'sd1;
      end
      default: begin
        c1_next.ip = npix - pixs;
        arg = 32'sd2 * c1_next.ip - 32'sd1;
      end
    endcase
    c1_next.sq_v = (in_item.func == hic_pkg::FUNC_R2N) ? SW'(arg) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c1 <= c1_next;
    end
  end

  // ---------------- integer square root, one result bit per stage
  logic sv [STEPS+1];
  ctx_t sc [STEPS+1];

  assign sv[0] = v1;
  assign sc[0] = c1;

  for (genvar k = 0; k < STEPS; k++) begin : g_sqrt
    localparam logic [SW-1:0] BIT = SW'(1) << (2 * (STEPS - 1 - k));
    ctx_t sn;
    ctx_t sq;
    logic vq;

    always_comb begin
      sn = sc[k];
      if (sc[k].sq_v >= sc[k].sq_r + BIT) begin
        sn.sq_v = sc[k].sq_v - (sc[k].sq_r + BIT);
        sn.sq_r = (sc[k].sq_r >> 1) + BIT;
      end else begin
        sn.sq_r = sc[k].sq_r >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vq <= 1'b0;
      end else if (en) begin
        vq <= sv[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq <= sn;
      end
    end

    assign sv[k+1] = vq;
    assign sc[k+1] = sq;
  end

  // ---------------- ring stage: ring size, shift and nr*(nr-1)
  logic vp;
  ctx_t cp, cp_next;

  always_comb begin
    logic signed [31:0] nside, rc, iring_c;
    logic signed [15:0] nrm1;
    logic signed [31:0] prodv;
    cp_next = sc[STEPS];
    nside   = 32'sd1 <<< cp_next.ord;
    rc      = 32'(cp_next.sq_r);
    iring_c = (rc + 32'sd1) >>> 1;
    if (cp_next.func == hic_pkg::FUNC_R2N) begin
      unique case (cp_next.region)
        hic_pkg::REG_NORTH: begin
          cp_next.iring  = iring_c;
          cp_next.nr     = 16'(iring_c);
          cp_next.kshift = 1'b0;
        end
        hic_pkg::REG_BELT: begin
          cp_next.iring  = 32'(cp_next.tmp) + nside;
          cp_next.nr     = 16'(nside);
          cp_next.kshift = cp_next.tmp[0];
        end
        default: begin
          cp_next.nr     = 16'(iring_c);
          cp_next.iring  = (nside <<< 2) - iring_c;
          cp_next.kshift = 1'b0;
        end
      endcase
    end else begin
      priority if (cp_next.jr < nside) begin
        cp_next.region = hic_pkg::REG_NORTH;
        cp_next.nr     = 16'(cp_next.jr);
        cp_next.kshift = 1'b0;
      end else if (cp_next.jr > 32'sd3 * nside) begin
        cp_next.region = hic_pkg::REG_SOUTH;
        cp_next.nr     = 16'((nside <<< 2) - cp_next.jr);
        cp_next.kshift = 1'b0;
      end else begin
        cp_next.region = hic_pkg::REG_BELT;
        cp_next.nr     = 16'(nside);
        cp_next.kshift = cp_next.jr[0] ^ nside[0];
      end
    end
    nrm1  = cp_next.nr - 16'sd1;
    prodv = cp_next.nr * nrm1;
    cp_next.prod = prodv;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vp <= 1'b0;
    end else if (en) begin
      vp <= sv[STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cp <= cp_next;
    end
  end

  // ---------------- position stage: ring position or ring start
  logic vq2;
  ctx_t cq, cq_next;

  always_comb begin
    logic signed [31:0] nside, npix, ncap, nr32, colv, two;
    cq_next = cp;
    nside   = 32'sd1 <<< cp.ord;
    npix    = 32'sd12 <<< {cp.ord, 1'b0};
    ncap    = (32'sd2 <<< {cp.ord, 1'b0}) - (32'sd2 <<< cp.ord);
    nr32    = 32'(cp.nr);
    two     = cp.prod <<< 1;
    colv    = 32'(hic_pkg::ring_col(cp.face));
    if (cp.func == hic_pkg::FUNC_R2N) begin
      unique case (cp.region)
        hic_pkg::REG_NORTH: cq_next.iphi = 32'(cp.pix) + 32'sd1 - two;
        hic_pkg::REG_BELT:  cq_next.iphi = cp.iphi;
        default:            cq_next.iphi = (nr32 <<< 2) + 32'sd1 - (cp.ip - two);
      endcase
    end else begin
      unique case (cp.region)
        hic_pkg::REG_NORTH: cq_next.ring_start = two;
        hic_pkg::REG_BELT: begin
          cq_next.ring_start = ncap + ((cp.jr - nside) <<< (cp.ord + 3'd2));
        end
        default: cq_next.ring_start = npix - ((cp.prod + (nr32 <<< 1)) <<< 1);
      endcase
      cq_next.jpn = colv * nr32 + 32'(cp.ix) - 32'(cp.iy) + 32'sd1 + 32'(cp.kshift);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vq2 <= 1'b0;
    end else if (en) begin
      vq2 <= vp;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cq <= cq_next;
    end
  end

  // ---------------- face stage: face for ring input, wrapped ring position for nested input
  logic vr;
  ctx_t cr, cr_next;

  always_comb begin
    logic signed [31:0] nside, nr32, t, ire, irm, ifm, ifp, fc, jp0, half;
    cr_next = cq;
    nside   = 32'sd1 <<< cq.ord;
    nr32    = 32'(cq.nr);
    t       = cq.iphi - 32'sd1;
    fc      = 32'(t >= nr32) + 32'(t >= (nr32 <<< 1)) + 32'(t >= (nr32 <<< 1) + nr32);
    ire     = 32'(cq.tmp) + 32'sd1;
    irm     = (nside <<< 1) + 32'sd2 - ire;
    ifm     = (cq.iphi - (ire >>> 1) + nside - 32'sd1) >>> cq.ord;
    ifp     = (cq.iphi - (irm >>> 1) + nside - 32'sd1) >>> cq.ord;
    unique case (cq.region)
      hic_pkg::REG_NORTH: begin
        // dropped for nested input, face already known there
      end
      hic_pkg::REG_BELT: begin
        if (ifp == ifm) begin
          fc = ifp | 32'sd4;
        end else if (ifp < ifm) begin
          fc = ifp;
        end else begin
          fc = ifm + 32'sd8;
        end
      end
      default: fc = fc + 32'sd8;
    endcase
    if (cq.func == hic_pkg::FUNC_R2N) begin
      cr_next.face = (fc < 32'sd0 || fc > 32'sd11) ? 4'd0 : 4'(fc);
    end
    // halve toward zero, then wrap onto the ring
    jp0  = (cq.jpn + (cq.jpn[31] ? 32'sd1 : 32'sd0)) >>> 1;
    half = nr32 <<< 2;
    if (jp0 > half) begin
      cr_next.jp = jp0 - half;
    end else if (jp0 < 32'sd1) begin
      cr_next.jp = jp0 + half;
    end else begin
      cr_next.jp = jp0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vr <= 1'b0;
    end else if (en) begin
      vr <= vq2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cr <= cr_next;
    end
  end

  // ---------------- face coordinates / ring result
  logic vs;
  ctx_t cs, cs_next;

  always_comb begin
    logic signed [31:0] nside, rowv, colv, pt;
    cs_next = cr;
    nside   = 32'sd1 <<< cr.ord;
    rowv    = 32'(hic_pkg::ring_row(cr.face));
    colv    = 32'(hic_pkg::ring_col(cr.face));
    cs_next.irt = cr.iring - (rowv <<< cr.ord) + 32'sd1;
    pt = (cr.iphi <<< 1) - colv * 32'(cr.nr) - 32'(cr.kshift) - 32'sd1;
    cs_next.ipt = (pt >= (nside <<< 1)) ? pt - (nside <<< 3) : pt;
    cs_next.res = cr.ring_start + cr.jp - 32'sd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vs <= 1'b0;
    end else if (en) begin
      vs <= vr;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cs <= cs_next;
    end
  end

  // ---------------- output register
  hic_pkg::hic_out_t out_next;

  always_comb begin
    logic signed [31:0] ixv, iyv;
    logic [31:0]        nest;
    ixv = (cs.ipt - cs.irt) >>> 1;
    iyv = (-cs.ipt - cs.irt) >>> 1;
    if (ixv < 32'sd0) ixv = '0;
    if (iyv < 32'sd0) iyv = '0;
    nest = (32'(cs.face) << {cs.ord, 1'b0}) + hic_pkg::spread16(ixv[15:0])
         + (hic_pkg::spread16(iyv[15:0]) << 1);
    out_next.index_error = cs.err;
    if (cs.err) begin
      out_next.converted_index = '0;
    end else if (cs.func == hic_pkg::FUNC_R2N) begin
      out_next.converted_index = nest[hic_pkg::PIX_W-1:0];
    end else begin
      out_next.converted_index = cs.res[hic_pkg::PIX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (en) begin
      res_valid <= vs;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_item <= out_next;
    end
  end

  `HIC_ASSERT_NOW(a_err_zero, clk, rst, res_valid && res_item.index_error,
                  res_item.converted_index == '0, "error result carries an index")

endmodule

// ===== rtl/core/healpix_index_converter_core.sv =====
// channel   | handshake                | payload
// ----------+--------------------------+--------------------------------------
// cfg       | cfg_valid / cfg_ready    | cfg_data: resolution order (4 bits)
// src       | src_valid / src_ready    | src_item: func, pixel_index
// res       | res_valid / res_ready    | res_item: converted_index, index_error
//
// one item per cycle sustained while results are taken, in both directions, one result per item
// from input accept to result the path runs through the front register, the
//   queue, the prep stage, a 14-stage square root line (one root bit per stage), four more
//   stages and the output register
// reset clears the order register to 0, the valid flags and the queue pointers
// a stalled result holds the back pipeline; the queue keeps the front taking items until it fills
module healpix_index_converter_core #(
  parameter int QUEUE_DEPTH = hic_pkg::QUEUE_DEPTH
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [hic_pkg::ORD_W-1:0] cfg_data,
  input  logic                      src_valid,
  output logic                      src_ready,
  input  hic_pkg::hic_in_t          src_item,
  output logic                      res_valid,
  input  logic                      res_ready,
  output hic_pkg::hic_out_t         res_item
);

  // classified items from front to queue
  logic               wq_valid;
  logic               wq_ready;
  hic_pkg::hic_work_t wq_item;

  // queue to back pipeline
  logic               bq_valid;
  logic               bq_ready;
  hic_pkg::hic_work_t bq_item;

  // front: order register, range check and region sort
  hic_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .src_valid (src_valid),
    .src_ready (src_ready),
    .src_item  (src_item),
    .wq_valid  (wq_valid),
    .wq_ready  (wq_ready),
    .wq_item   (wq_item)
  );

  // short queue decoupling the two halves
  hic_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (wq_valid),
    .push_ready (wq_ready),
    .push_item  (wq_item),
    .pop_valid  (bq_valid),
    .pop_ready  (bq_ready),
    .pop_item   (bq_item)
  );

  // back: the conversion pipeline and the output register
  hic_back u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (bq_valid),
    .in_ready  (bq_ready),
    .in_item   (bq_item),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_item  (res_item)
  );

endmodule
